### hdl/note_envelope_controller_top_defines.svh
// Assertion macros for the note envelope controller.
`ifndef NOTE_ENVELOPE_CONTROLLER_TOP_DEFINES_SVH
`define NOTE_ENVELOPE_CONTROLLER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define NEC_ASSERT_IMP(label, clk, rst, ant, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
      else $error("note envelope controller: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define NEC_ASSERT_NEXT(label, clk, rst, ant, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
      else $error("note envelope controller: next-cycle check failed");
`else
`define NEC_ASSERT_IMP(label, clk, rst, ant, cons)
`define NEC_ASSERT_NEXT(label, clk, rst, ant, cons)
`endif
`endif

### hdl/nec_pkg.sv
`timescale 1ns / 1ps
package nec_pkg;

   localparam int unsigned BasePeriodWidth  = 22;
   localparam int unsigned LevelWidth       = 16;
   localparam int unsigned AttackDurWidth   = 24;
   localparam int unsigned ReleaseDurWidth  = 32;
   localparam int unsigned TimeWidth        = 32;
   localparam int unsigned VelocityWidth    = 7;
   localparam int unsigned BendWidth        = 16;
   localparam int unsigned OffsetWidth      = 24;
   localparam int unsigned PeriodWidth      = 25;
   localparam int unsigned ProductWidth     = AttackDurWidth + VelocityWidth;
   localparam int unsigned OpWidth          = 3;

   localparam int unsigned ReqDataWidth     = 80;
   localparam int unsigned RspDataWidth     = 48;
   localparam int unsigned CsrAddrWidth     = 5;
   localparam int unsigned CsrDataWidth     = 32;

   localparam logic [BasePeriodWidth-1:0] BasePeriodReset  = 22'd56818;
   localparam logic [LevelWidth-1:0]      AttackLevelReset = 16'd1000;
   localparam logic [LevelWidth-1:0]      SustainLevelReset = 16'd417;
   localparam logic [LevelWidth-1:0]      ReleaseLevelReset = 16'd1000;
   localparam logic [AttackDurWidth-1:0]  AttackDurReset   = 24'd30000;
   localparam logic [ReleaseDurWidth-1:0] ReleaseDurReset  = 32'd15000;

   // Full velocity; start scales the attack time by velocity / VelFull.
   localparam int unsigned VelFull = 127;

   typedef enum logic [OpWidth-1:0] {
      OP_UPDATE     = 3'd0,
      OP_START      = 3'd1,
      OP_STOP       = 3'd2,
      OP_BEND       = 3'd3,
      OP_SET_OFFSET = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      REG_BASE_PERIOD  = 3'd0,
      REG_ATTACK_LEVEL = 3'd1,
      REG_SUSTAIN_LEVEL = 3'd2,
      REG_RELEASE_LEVEL = 3'd3,
      REG_ATTACK_DUR   = 3'd4,
      REG_RELEASE_DUR  = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic                          started;
      logic signed [PeriodWidth-1:0] period;
      logic                          drive_valid;
      logic                          inverted;
      logic [LevelWidth-1:0]         amplitude;
   } result_type;

endpackage

### hdl/note_envelope_controller_top.sv
`timescale 1ns / 1ps
// A word accepted on req_ goes to the result register behind rsp_, or to the skid entry.
// Throughput: one word per cycle; a two-entry output stage keeps req_tready high
// while a single finished result waits, so input stalls only when both entries are full.
// Reset: synchronous, active high; clears phase, timers, offset and output stage,
// and loads register defaults.
`include "note_envelope_controller_top_defines.svh"
module note_envelope_controller_top (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: now_us[31:0], velocity[38:32], bend[54:39], offset[78:55], zero pad
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [nec_pkg::ReqDataWidth-1:0]   req_tdata,
   // req_tuser: operation[2:0]
   input  logic [nec_pkg::OpWidth-1:0]        req_tuser,
   // rsp_tdata: amplitude[15:0], inverted[16], period[41:17], started[42], zero pad
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [nec_pkg::RspDataWidth-1:0]   rsp_tdata,
   // rsp_tuser: drive_valid[0]
   output logic                               rsp_tuser,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [nec_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [nec_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [nec_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                               csr_pready
);
   import nec_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_ATTACK  = 2'd1,
      PH_SUSTAIN = 2'd2,
      PH_RELEASE = 2'd3
   } phase_type;

   // Configuration registers
   logic [BasePeriodWidth-1:0] base_period_ff;
   logic [LevelWidth-1:0]      attack_level_ff;
   logic [LevelWidth-1:0]      sustain_level_ff;
   logic [LevelWidth-1:0]      release_level_ff;
   logic [AttackDurWidth-1:0]  attack_dur_ff;
   logic [ReleaseDurWidth-1:0] release_dur_ff;

   // Envelope state; attack_prod holds attack_duration * velocity, the scaled
   // attack time being attack_prod / 127 rounded down.
   phase_type                         phase_ff, phase_in;
   logic [TimeWidth-1:0]              start_time_ff, start_time_in;
   logic [ProductWidth-1:0]           attack_prod_ff, attack_prod_in;
   logic signed [OffsetWidth-1:0]     offset_ff, offset_in;

   // Output stage: result register plus skid entry
   logic       out_valid_ff;
   result_type out_data_ff;
   logic       skid_valid_ff;
   result_type skid_data_ff;

   // Input word fields
   op_type                        op;
   logic [TimeWidth-1:0]          now_us;
   logic [VelocityWidth-1:0]      velocity;
   logic signed [BendWidth-1:0]   bend;
   logic signed [OffsetWidth-1:0] offset;

   logic                          req_accept;
   logic                          csr_write;
   reg_index_type                 csr_index;

   logic [TimeWidth-1:0]          elapsed;
   logic [AttackDurWidth-1:0]     elapsed_low;
   logic [ProductWidth:0]         elapsed_scaled;
   logic                          attack_done;
   logic                          release_done;
   logic signed [BendWidth-1:0]   bend_half;
   result_type                    result;

   assign op       = op_type'(req_tuser);
   assign now_us   = req_tdata[31:0];
   assign velocity = req_tdata[38:32];
   assign bend     = req_tdata[54:39];
   assign offset   = req_tdata[78:55];

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[4:2]);

   // Attack runs out once floor(prod / 127) <= elapsed, i.e. prod <= 127 * elapsed + 126.
   // Any elapsed time of 2^24 or more exceeds every scaled attack time.
   assign elapsed        = now_us - start_time_ff;
   assign elapsed_low    = elapsed[AttackDurWidth-1:0];
   assign elapsed_scaled = {1'b0, elapsed_low, {VelocityWidth{1'b0}}}
                         - {{(VelocityWidth+1){1'b0}}, elapsed_low}
                         + (ProductWidth+1)'(VelFull - 1);
   assign attack_done    = (elapsed[TimeWidth-1:AttackDurWidth] != '0)
                         || (elapsed_scaled >= {1'b0, attack_prod_ff});
   assign release_done   = elapsed >= release_dur_ff;

   // Halve the bend toward zero: add one to negative values before the shift.
   assign bend_half = (bend + $signed(BendWidth'(bend[BendWidth-1]))) >>> 1;

   always_comb begin
      phase_in       = phase_ff;
      start_time_in  = start_time_ff;
      attack_prod_in = attack_prod_ff;
      offset_in      = offset_ff;
      result         = '0;

      unique case (op)
         OP_UPDATE: begin
            result.drive_valid = 1'b1;
            unique case (phase_ff)
               PH_ATTACK: begin
                  result.amplitude = attack_level_ff;
                  if (attack_done) begin
                     phase_in = PH_SUSTAIN;
                  end
               end
               PH_SUSTAIN: begin
                  result.amplitude = sustain_level_ff;
               end
               PH_RELEASE: begin
                  result.amplitude = release_level_ff;
                  result.inverted  = 1'b1;
                  if (release_done) begin
                     phase_in = PH_IDLE;
                  end
               end
               default: begin
               end
            endcase
         end
         OP_START: begin
            start_time_in  = now_us;
            attack_prod_in = ProductWidth'(attack_dur_ff * velocity);
            phase_in       = PH_ATTACK;
         end
         OP_STOP: begin
            if (phase_ff != PH_IDLE) begin
               start_time_in = now_us;
               phase_in      = PH_RELEASE;
            end
         end
         OP_BEND: begin
            offset_in = OffsetWidth'(bend_half);
         end
         OP_SET_OFFSET: begin
            offset_in = offset;
         end
         default: begin
            // Unknown operations leave the state alone.
         end
      endcase

      result.period  = $signed({{(PeriodWidth-BasePeriodWidth){1'b0}}, base_period_ff})
                     + PeriodWidth'(offset_in);
      result.started = (phase_in != PH_IDLE);
   end

   // Hold state and the output stage; advance state on every accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         start_time_ff  <= '0;
         attack_prod_ff <= '0;
         offset_ff      <= '0;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         if (req_accept) begin
            phase_ff       <= phase_in;
            start_time_ff  <= start_time_in;
            attack_prod_ff <= attack_prod_in;
            offset_ff      <= offset_in;
            if (out_valid_ff && !rsp_tready) begin
               // Result register still waits: park the new word in the skid entry.
               skid_valid_ff <= 1'b1;
               skid_data_ff  <= result;
            end else begin
               out_valid_ff <= 1'b1;
               out_data_ff  <= result;
            end
         end else if (!out_valid_ff || rsp_tready) begin
            // Drain the skid entry into the result register.
            out_valid_ff  <= skid_valid_ff;
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         base_period_ff   <= BasePeriodReset;
         attack_level_ff  <= AttackLevelReset;
         sustain_level_ff <= SustainLevelReset;
         release_level_ff <= ReleaseLevelReset;
         attack_dur_ff    <= AttackDurReset;
         release_dur_ff   <= ReleaseDurReset;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_BASE_PERIOD:   base_period_ff   <= csr_pwdata[BasePeriodWidth-1:0];
            REG_ATTACK_LEVEL:  attack_level_ff  <= csr_pwdata[LevelWidth-1:0];
            REG_SUSTAIN_LEVEL: sustain_level_ff <= csr_pwdata[LevelWidth-1:0];
            REG_RELEASE_LEVEL: release_level_ff <= csr_pwdata[LevelWidth-1:0];
            REG_ATTACK_DUR:    attack_dur_ff    <= csr_pwdata[AttackDurWidth-1:0];
            REG_RELEASE_DUR:   release_dur_ff   <= csr_pwdata[ReleaseDurWidth-1:0];
            default: begin
               // Drop writes beyond the register list.
            end
         endcase
      end
   end

   // Register readback
   always_comb begin
      unique case (csr_index)
         REG_BASE_PERIOD:   csr_prdata = CsrDataWidth'(base_period_ff);
         REG_ATTACK_LEVEL:  csr_prdata = CsrDataWidth'(attack_level_ff);
         REG_SUSTAIN_LEVEL: csr_prdata = CsrDataWidth'(sustain_level_ff);
         REG_RELEASE_LEVEL: csr_prdata = CsrDataWidth'(release_level_ff);
         REG_ATTACK_DUR:    csr_prdata = CsrDataWidth'(attack_dur_ff);
         REG_RELEASE_DUR:   csr_prdata = release_dur_ff;
         default:           csr_prdata = '0;
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_data_ff.drive_valid;
   assign rsp_tdata  = {{(RspDataWidth-43){1'b0}}, out_data_ff.started, out_data_ff.period,
                        out_data_ff.inverted, out_data_ff.amplitude};

   // The skid entry fills only behind a waiting result.
   `NEC_ASSERT_IMP(skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   // An accepted word always leaves a result pending.
   `NEC_ASSERT_NEXT(accept_gives_result, clock, reset, req_accept, out_valid_ff)
   // A start enters attack from any phase.
   `NEC_ASSERT_NEXT(start_enters_attack, clock, reset, req_accept && (op == OP_START),
                    phase_ff == PH_ATTACK)

endmodule

### tb/note_envelope_controller_top_tb.sv
`timescale 1ns / 1ps
module note_envelope_controller_top_tb;
   import nec_pkg::*;

   localparam int unsigned CycleLimit = 200000;
   // From this word count on, both sides run without idling.
   localparam int unsigned CalmFrom   = 675;
   // Register slots past the last defined one; writes there must change nothing.
   localparam logic [2:0]  SpareRegIndex = 3'd6;
   localparam logic [2:0]  LastRegSlot   = 3'd7;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_ATTACK  = 2'd1,
      PH_SUSTAIN = 2'd2,
      PH_RELEASE = 2'd3
   } env_phase_type;

   // One drive word as the block reports it; drive_valid travels on rsp_tuser.
   typedef struct packed {
      logic [LevelWidth-1:0]  amplitude;
      logic                   inverted;
      logic                   drive_valid;
      logic [PeriodWidth-1:0] period;
      logic                   started;
   } drive_word_type;

   // Envelope tracker: mirrors the register file and the phase state, works out the
   // drive word for each accepted request and checks each delivered word against it.
   class envelope_tracker;
      logic [BasePeriodWidth-1:0]    base_period;
      logic [LevelWidth-1:0]         attack_level;
      logic [LevelWidth-1:0]         sustain_level;
      logic [LevelWidth-1:0]         release_level;
      logic [AttackDurWidth-1:0]     attack_time_us;
      logic [ReleaseDurWidth-1:0]    release_time_us;
      env_phase_type                 phase;
      logic [TimeWidth-1:0]          phase_start;
      logic [AttackDurWidth-1:0]     scaled_attack;
      logic signed [OffsetWidth-1:0] pitch_offset;
      drive_word_type                expected_drive[$];
      int unsigned                   items_noted;
      int unsigned                   failures;

      function new();
         base_period     = BasePeriodReset;
         attack_level    = AttackLevelReset;
         sustain_level   = SustainLevelReset;
         release_level   = ReleaseLevelReset;
         attack_time_us  = AttackDurReset;
         release_time_us = ReleaseDurReset;
         phase           = PH_IDLE;
         phase_start     = '0;
         scaled_attack   = '0;
         pitch_offset    = '0;
         items_noted     = 0;
         failures        = 0;
      endfunction

      function void write_register(logic [CsrAddrWidth-1:0] addr,
                                   logic [CsrDataWidth-1:0] value);
         case (addr[CsrAddrWidth-1:2])
            REG_BASE_PERIOD:   base_period     = value[BasePeriodWidth-1:0];
            REG_ATTACK_LEVEL:  attack_level    = value[LevelWidth-1:0];
            REG_SUSTAIN_LEVEL: sustain_level   = value[LevelWidth-1:0];
            REG_RELEASE_LEVEL: release_level   = value[LevelWidth-1:0];
            REG_ATTACK_DUR:    attack_time_us  = value[AttackDurWidth-1:0];
            REG_RELEASE_DUR:   release_time_us = value[ReleaseDurWidth-1:0];
            default: ;
         endcase
      endfunction

      function void note_item(logic [OpWidth-1:0] op, logic [ReqDataWidth-1:0] data);
         logic [TimeWidth-1:0]          now_us;
         logic [TimeWidth-1:0]          elapsed;
         logic [VelocityWidth-1:0]      velocity;
         logic signed [BendWidth-1:0]   bend;
         logic signed [OffsetWidth-1:0] offset;
         logic [ProductWidth-1:0]       product;
         drive_word_type                w;
         int                            period_sum;
         now_us   = data[31:0];
         velocity = data[38:32];
         bend     = data[54:39];
         offset   = data[78:55];
         w        = '0;
         case (op)
            OP_UPDATE: begin
               elapsed       = now_us - phase_start;
               w.drive_valid = 1'b1;
               case (phase)
                  PH_ATTACK: begin
                     w.amplitude = attack_level;
                     if (elapsed >= scaled_attack) phase = PH_SUSTAIN;
                  end
                  PH_SUSTAIN: w.amplitude = sustain_level;
                  PH_RELEASE: begin
                     w.amplitude = release_level;
                     w.inverted  = 1'b1;
                     if (elapsed >= release_time_us) phase = PH_IDLE;
                  end
                  default: ;
               endcase
            end
            OP_START: begin
               product       = attack_time_us * velocity;
               scaled_attack = AttackDurWidth'(product / VelFull);
               phase_start   = now_us;
               phase         = PH_ATTACK;
            end
            OP_STOP: begin
               if (phase != PH_IDLE) begin
                  phase_start = now_us;
                  phase       = PH_RELEASE;
               end
            end
            // signed division truncates toward zero, as the bend rule wants
            OP_BEND:       pitch_offset = OffsetWidth'(int'(bend) / 2);
            OP_SET_OFFSET: pitch_offset = offset;
            default: ;
         endcase
         period_sum = int'(base_period) + int'(pitch_offset);
         w.period   = period_sum[PeriodWidth-1:0];
         w.started  = (phase != PH_IDLE);
         expected_drive.push_back(w);
         items_noted++;
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            failures++;
         end
      endfunction

      function void check_drive(logic [RspDataWidth-1:0] data, logic user);
         drive_word_type w;
         if (expected_drive.size() == 0) begin
            $error("drive word 0x%0h arrived with nothing expected", data);
            failures++;
            return;
         end
         w = expected_drive.pop_front();
         compare_field("amplitude", w.amplitude, data[15:0]);
         compare_field("inverted", w.inverted, data[16]);
         compare_field("period", w.period, data[41:17]);
         compare_field("started", w.started, data[42]);
         compare_field("drive_valid", w.drive_valid, user);
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata = '0;
   logic [OpWidth-1:0]      req_tuser = OP_UPDATE;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    rsp_tuser;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [CsrDataWidth-1:0] csr_pwdata = '0;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   envelope_tracker tracker = new();
   int unsigned     items_sent = 0;
   logic            idling = 1'b0;
   logic [31:0]     stim_now_us = '0;
   int unsigned     rsp_hold = 0;

   note_envelope_controller_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Observe all three ports at each rising edge; values read here are the ones
   // the block sampled, since every driver updates through nonblocking assignments.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            tracker.write_register(csr_paddr, csr_pwdata);
         if (req_tvalid && req_tready)
            tracker.note_item(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready)
            tracker.check_drive(rsp_tdata, rsp_tuser);
      end
   end

   // Result side: drop tready in bursts, starting at random, while idling is on.
   always @(posedge clock) begin
      if (idling && rsp_hold == 0 && $urandom_range(0, 5) == 0)
         rsp_hold = $urandom_range(1, 3);
      if (rsp_hold != 0) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Hold one word on req_ until the block takes it, after an optional idle burst.
   // Return at the edge of acceptance so the next word follows back to back.
   task automatic send_word(input logic [OpWidth-1:0] op,
                            input logic [ReqDataWidth-1:0] data);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Pack the fields from the lowest bit up: now_us, velocity, bend, offset, pad.
   task automatic send_op(input logic [OpWidth-1:0] op, input logic [31:0] now_us,
                          input logic [6:0] velocity = '0,
                          input logic [15:0] bend = '0,
                          input logic [23:0] offset = '0);
      send_word(op, {1'b0, offset, bend, velocity, now_us});
   endtask

   // Advance the microsecond clock by a random step of up to span.
   task automatic advance(input int unsigned span);
      stim_now_us += $urandom_range(0, span);
   endtask

   // Play one note: start, a few updates with pitch changes mixed in, then usually
   // a stop followed by updates that run into or through the release.
   task automatic play_note(input int unsigned span);
      advance(span);
      send_op(OP_START, stim_now_us, 7'($urandom_range(0, 127)));
      repeat ($urandom_range(1, 5)) begin
         advance(span);
         case ($urandom_range(0, 7))
            0:       send_op(OP_BEND, stim_now_us, '0, 16'($urandom));
            1:       send_op(OP_SET_OFFSET, stim_now_us, '0, '0, 24'($urandom));
            default: send_op(OP_UPDATE, stim_now_us);
         endcase
      end
      if ($urandom_range(0, 5) != 0) begin
         advance(span);
         send_op(OP_STOP, stim_now_us);
         repeat ($urandom_range(1, 4)) begin
            advance(span);
            send_op(OP_UPDATE, stim_now_us);
         end
      end
   endtask

   // Any code, unknown ones too, with every field random and at times a wild timestamp.
   task automatic noise_word();
      logic [31:0] now_us;
      now_us = ($urandom_range(0, 3) == 0) ? $urandom : stim_now_us + $urandom_range(0, 50);
      send_word(OpWidth'($urandom_range(0, 7)),
                {1'b0, 24'($urandom), 16'($urandom), 7'($urandom), now_us});
   endtask

   // Mostly well-formed notes, some noise; idle in stretches, never near the end.
   task automatic random_traffic(input int unsigned target, input int unsigned span);
      while (items_sent < target) begin
         idling = (items_sent < CalmFrom) && ((items_sent / 60) % 3 != 2);
         if ($urandom_range(0, 9) < 7)
            play_note(span);
         else
            noise_word();
      end
   endtask

   // Wait until every word sent has been noted and every drive word has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (tracker.items_noted != items_sent || tracker.expected_drive.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the write lands at the edge that ends the access.
   task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   task automatic release_bus();
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("note_envelope_controller_top test failed");
      $finish;
   end

   initial begin : stimulus
      logic [31:0] t0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idling = 1'b1;

      // Directed words on reset registers: idle behavior, bend rounding, offset
      // extremes, unknown codes, then a full note across the timestamp wrap.
      send_op(OP_UPDATE, 32'd0);
      send_op(OP_STOP, 32'd5);
      send_op(OP_BEND, 32'd6, '0, 16'h8000);
      send_op(OP_BEND, 32'd7, '0, 16'h7FFF);
      send_op(OP_BEND, 32'd8, '0, 16'hFFFF);
      send_op(OP_BEND, 32'd9, '0, 16'hFFFD);
      send_op(OP_SET_OFFSET, 32'd10, '0, '0, 24'h800000);
      send_op(OP_SET_OFFSET, 32'd11, '0, '0, 24'h7FFFFF);
      send_word(OpWidth'(5), '1 >> 1);
      send_word(OpWidth'(6), '1 >> 1);
      send_word(OpWidth'(7), '1 >> 1);
      t0 = 32'hFFFF_FFF0;
      send_op(OP_START, t0, 7'd127);
      send_op(OP_UPDATE, t0 + 32'd29999);
      send_op(OP_UPDATE, t0 + 32'd30000);
      send_op(OP_UPDATE, t0 + 32'd40000);
      t0 = t0 + 32'd50000;
      send_op(OP_STOP, t0);
      send_op(OP_UPDATE, t0 + 32'd14999);
      send_op(OP_UPDATE, t0 + 32'd15000);
      send_op(OP_UPDATE, t0 + 32'd15001);
      // zero velocity leaves no attack: the first update still reports attack level
      send_op(OP_START, t0 + 32'd16000, 7'd0);
      send_op(OP_UPDATE, t0 + 32'd16000);
      send_op(OP_START, t0 + 32'd17000, 7'd1);
      send_op(OP_STOP, t0 + 32'd17010);
      // restart straight out of release
      send_op(OP_START, t0 + 32'd17020, 7'd64);
      send_op(OP_SET_OFFSET, t0 + 32'd17030, '0, '0, 24'd0);
      stim_now_us = t0 + 32'd17040;
      random_traffic(225, 20000);

      // Short envelopes, base period wrapping to zero, zeroed A/R levels, instant release.
      drain();
      write_reg(REG_BASE_PERIOD, 32'hFFC0_0000);
      write_reg(REG_ATTACK_LEVEL, 32'h0);
      write_reg(REG_SUSTAIN_LEVEL, 32'hFFFF_FFFF);
      write_reg(REG_RELEASE_LEVEL, 32'hFFFF_0000);
      write_reg(REG_ATTACK_DUR, 32'hFF00_0064);
      write_reg(REG_RELEASE_DUR, 32'h0);
      write_reg(SpareRegIndex, 32'hFFFF_FFFF);
      write_reg(LastRegSlot, 32'hFFFF_FFFF);
      release_bus();
      send_op(OP_SET_OFFSET, stim_now_us, '0, '0, 24'h800000);
      random_traffic(425, 80);

      // Every register but sustain (zero) at top; release ends only at the full 2^32-1 span.
      drain();
      write_reg(REG_BASE_PERIOD, 32'hFFFF_FFFF);
      write_reg(REG_ATTACK_LEVEL, 32'hFFFF_FFFF);
      write_reg(REG_SUSTAIN_LEVEL, 32'h0);
      write_reg(REG_RELEASE_LEVEL, 32'h0000_FFFF);
      write_reg(REG_ATTACK_DUR, 32'hFFFF_FFFF);
      write_reg(REG_RELEASE_DUR, 32'hFFFF_FFFF);
      release_bus();
      t0 = stim_now_us;
      send_op(OP_START, t0, 7'd127);
      send_op(OP_STOP, t0 + 32'd5);
      send_op(OP_UPDATE, t0 + 32'd3);
      send_op(OP_UPDATE, t0 + 32'd4);
      send_op(OP_SET_OFFSET, t0 + 32'd6, '0, '0, 24'h7FFFFF);
      send_op(OP_SET_OFFSET, t0 + 32'd7, '0, '0, 24'h800000);
      stim_now_us = t0 + 32'd10;
      random_traffic(625, 32'h0100_0000);

      // Random settings with durations short enough to cross often.
      drain();
      write_reg(REG_BASE_PERIOD, $urandom);
      write_reg(REG_ATTACK_LEVEL, $urandom);
      write_reg(REG_SUSTAIN_LEVEL, $urandom);
      write_reg(REG_RELEASE_LEVEL, $urandom);
      write_reg(REG_ATTACK_DUR, $urandom_range(0, 4000));
      write_reg(REG_RELEASE_DUR, $urandom_range(0, 3000));
      release_bus();
      random_traffic(825, 3000);

      idling = 1'b0;
      drain();
      repeat (4) @(posedge clock);
      if (tracker.failures == 0)
         $display("note_envelope_controller_top test passed");
      else
         $display("note_envelope_controller_top test failed");
      $finish;
   end
endmodule

### sim.f
+incdir+hdl
hdl/nec_pkg.sv
hdl/note_envelope_controller_top.sv
tb/note_envelope_controller_top_tb.sv
